>>> hw/rtl/sld_pkg.sv
package sld_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned HDR_LEN = 6;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_FIRST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_SECOND  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 2'd3;

  // reset values of the configuration registers
  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'haa;
  localparam logic [BYTE_W-1:0] TYPE1_RESET  = 8'h61;
  localparam logic [BYTE_W-1:0] TYPE2_RESET  = 8'had;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_HEAD,
    ST_CHECK,
    ST_RELEASE,
    ST_BODY,
    ST_PASS
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_HUNT_LOAD,
    OP_HEAD_LOAD,
    OP_RESYNC,
    OP_RELEASE_INIT,
    OP_RELEASE_EMIT,
    OP_CAPTURE,
    OP_PASS_EMIT
  } op_e;

  typedef struct packed {
    logic sync_hit;
    logic hdr_last;
    logic hdr_ok;
    logic resync_found;
    logic rel_last;
    logic pos_lt_len;
    logic pos_eq_len;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/sld_if.sv
interface sld_in_if;
  import sld_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sld_out_if;
  import sld_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_first;
  logic              frame_last;
  logic              sum_bad;

  modport source (output valid, output frame_byte, output frame_first,
                  output frame_last, output sum_bad, input ready);
  modport sink   (input valid, input frame_byte, input frame_first,
                  input frame_last, input sum_bad, output ready);
endinterface

>>> hw/rtl/sld_ctrl.sv
module sld_ctrl
  import sld_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    rx_valid_i,
  input  status_t status_i,
  output logic    rx_ready_o,
  output op_e     op_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = rx_valid_i && rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_HUNT: begin
        if (accept && status_i.sync_hit) state_d = ST_HEAD;
      end
      ST_HEAD: begin
        if (accept && status_i.hdr_last) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.hdr_ok) state_d = ST_RELEASE;
        else if (status_i.resync_found) state_d = ST_HEAD;
        else state_d = ST_HUNT;
      end
      ST_RELEASE: begin
        if (status_i.out_free && status_i.rel_last) state_d = ST_BODY;
      end
      ST_BODY: begin
        if (accept) state_d = ST_PASS;
      end
      ST_PASS: begin
        if (status_i.out_free) begin
          if (status_i.pos_lt_len || status_i.pos_eq_len) state_d = ST_BODY;
          else state_d = ST_HUNT;
        end
      end
      default: state_d = ST_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    rx_ready_o = 1'b0;
    op_o       = OP_NONE;
    unique case (state_q)
      ST_HUNT: begin
        rx_ready_o = 1'b1;
        if (rx_valid_i && status_i.sync_hit) op_o = OP_HUNT_LOAD;
      end
      ST_HEAD: begin
        rx_ready_o = 1'b1;
        if (rx_valid_i) op_o = OP_HEAD_LOAD;
      end
      ST_CHECK: begin
        op_o = status_i.hdr_ok ? OP_RELEASE_INIT : OP_RESYNC;
      end
      ST_RELEASE: begin
        if (status_i.out_free) op_o = OP_RELEASE_EMIT;
      end
      ST_BODY: begin
        rx_ready_o = 1'b1;
        if (rx_valid_i) op_o = OP_CAPTURE;
      end
      ST_PASS: begin
        if (status_i.out_free) op_o = OP_PASS_EMIT;
      end
      default: begin
        rx_ready_o = 1'b0;
        op_o       = OP_NONE;
      end
    endcase
  end

endmodule

>>> hw/rtl/sld_datapath.sv
module sld_datapath
  import sld_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  input  op_e                   op_i,
  output status_t               status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [BYTE_W-1:0]     frame_byte_o,
  output logic                  frame_first_o,
  output logic                  frame_last_o,
  output logic                  sum_bad_o
);

  logic [BYTE_W-1:0] sync_q, type1_q, type2_q;
  logic              chk_en_q;

  logic [BYTE_W-1:0] hdr_q [HDR_LEN];
  logic [BYTE_W-1:0] hdr_d [HDR_LEN];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [BYTE_W-1:0] trail_hi_q, trail_hi_d;
  logic [BYTE_W-1:0] byte_q, byte_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] obyte_q, obyte_d;
  logic              ofirst_q, ofirst_d;
  logic              olast_q, olast_d;
  logic              obad_q, obad_d;

  logic [LEN_W-1:0]  hdr_len;
  logic              found;
  logic [CNT_W-1:0]  shift;
  logic [CNT_W:0]    src;
  logic              out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= SYNC_RESET;
      type1_q  <= TYPE1_RESET;
      type2_q  <= TYPE2_RESET;
      chk_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SYNC_VALUE:   sync_q   <= cfg_data_i;
        REG_TYPE_FIRST:   type1_q  <= cfg_data_i;
        REG_TYPE_SECOND:  type2_q  <= cfg_data_i;
        REG_CHECK_ENABLE: chk_en_q <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  assign hdr_len  = {hdr_q[1], hdr_q[2]};
  assign out_free = !out_valid_q || out_ready_i;

  // lowest later header offset holding the sync byte
  always_comb begin
    found = 1'b0;
    shift = '0;
    for (int k = HDR_LEN - 1; k >= 1; k--) begin
      if (hdr_q[k] == sync_q) begin
        found = 1'b1;
        shift = CNT_W'(k);
      end
    end
  end

  always_comb begin
    status_o.sync_hit     = (rx_byte_i == sync_q);
    status_o.hdr_last     = (cnt_q == CNT_W'(HDR_LEN - 1));
    status_o.hdr_ok       = (hdr_q[4] == type1_q) && (hdr_q[5] == type2_q) &&
                            (hdr_len >= LEN_W'(HDR_LEN));
    status_o.resync_found = found;
    status_o.rel_last     = (cnt_q == CNT_W'(HDR_LEN - 1));
    status_o.pos_lt_len   = (pos_q < {1'b0, len_q});
    status_o.pos_eq_len   = (pos_q == {1'b0, len_q});
    status_o.out_free     = out_free;
  end

  always_comb begin
    hdr_d       = hdr_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    trail_hi_d  = trail_hi_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q && !out_ready_i;
    obyte_d     = obyte_q;
    ofirst_d    = ofirst_q;
    olast_d     = olast_q;
    obad_d      = obad_q;
    src         = '0;
    unique case (op_i)
      OP_NONE: ;
      OP_HUNT_LOAD: begin
        hdr_d[0] = rx_byte_i;
        cnt_d    = CNT_W'(1);
      end
      OP_HEAD_LOAD: begin
        if (cnt_q < CNT_W'(HDR_LEN)) hdr_d[cnt_q] = rx_byte_i;
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_RESYNC: begin
        // move the new header start down to offset zero
        for (int j = 0; j < HDR_LEN; j++) begin
          src = (CNT_W+1)'(j) + {1'b0, shift};
          if (src < (CNT_W+1)'(HDR_LEN)) hdr_d[j] = hdr_q[src[CNT_W-1:0]];
        end
        cnt_d = found ? (CNT_W'(HDR_LEN) - shift) : '0;
      end
      OP_RELEASE_INIT: begin
        len_d = hdr_len;
        sum_d = '0;
        cnt_d = '0;
      end
      OP_RELEASE_EMIT: begin
        out_valid_d = 1'b1;
        obyte_d     = hdr_q[cnt_q];
        ofirst_d    = (cnt_q == '0);
        olast_d     = 1'b0;
        obad_d      = 1'b0;
        sum_d       = sum_q + {{(SUM_W-BYTE_W){1'b0}}, hdr_q[cnt_q]};
        if (cnt_q == CNT_W'(HDR_LEN - 1)) begin
          cnt_d = '0;
          pos_d = POS_W'(HDR_LEN);
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_CAPTURE: begin
        byte_d = rx_byte_i;
      end
      OP_PASS_EMIT: begin
        out_valid_d = 1'b1;
        obyte_d     = byte_q;
        ofirst_d    = 1'b0;
        olast_d     = 1'b0;
        obad_d      = 1'b0;
        if (pos_q < {1'b0, len_q}) begin
          sum_d = sum_q + {{(SUM_W-BYTE_W){1'b0}}, byte_q};
          pos_d = pos_q + POS_W'(1);
        end else if (pos_q == {1'b0, len_q}) begin
          trail_hi_d = byte_q;
          pos_d      = pos_q + POS_W'(1);
        end else begin
          olast_d = 1'b1;
          obad_d  = chk_en_q && ({trail_hi_q, byte_q} != sum_q);
          pos_d   = '0;
        end
      end
      default: ;
    endcase
  end

  // header store, payload holding and output data registers
  always_ff @(posedge clk_i) begin
    hdr_q    <= hdr_d;
    byte_q   <= byte_d;
    obyte_q  <= obyte_d;
    ofirst_q <= ofirst_d;
    olast_q  <= olast_d;
    obad_q   <= obad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      trail_hi_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      trail_hi_q  <= trail_hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_byte_o  = obyte_q;
  assign frame_first_o = ofirst_q;
  assign frame_last_o  = olast_q;
  assign sum_bad_o     = obad_q;

endmodule

>>> hw/rtl/sync_length_sum_deframer_unit.sv
// sync, length and checksum deframer
// rx_i carries one received serial byte per item; frame_o carries the bytes
// of each accepted frame in order, with frame_first on the sync byte,
// frame_last on the final trailer byte and sum_bad beside it when the
// checksum compare is enabled and the 16-bit sum disagrees with the trailer
// bytes outside a frame, and headers that fail the type or length check,
// give no item; a failed header resynchronises on the next sync byte it holds
// the configuration port writes sync value, two type bytes and check enable;
// write it only while the block is idle
// timing: while hunting or collecting the header, one byte is taken per
// cycle; the sixth header byte is followed by a check state and then a
// release state that outputs the six header bytes as the output register
// frees; each body byte is captured into the capture register and is then
// moved into the output register once that register is free
// the output register holds a finished item while the receiver stalls; one
// more body byte can still be accepted into the capture register meanwhile
// reset clears the state machine, counters, sum and output valid, and loads
// the register reset values; the header store needs no clearing
module sync_length_sum_deframer_unit
  import sld_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sld_in_if.sink                rx_i,
  sld_out_if.source             frame_o
);

  // commands and status between sequencer and datapath
  op_e     op;
  status_t status;

  sld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .status_i   (status),
    .rx_ready_o (rx_i.ready),
    .op_o       (op)
  );

  sld_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .rx_byte_i     (rx_i.rx_byte),
    .op_i          (op),
    .status_o      (status),
    .out_ready_i   (frame_o.ready),
    .out_valid_o   (frame_o.valid),
    .frame_byte_o  (frame_o.frame_byte),
    .frame_first_o (frame_o.frame_first),
    .frame_last_o  (frame_o.frame_last),
    .sum_bad_o     (frame_o.sum_bad)
  );

endmodule
